// File: rtl/sbpf_pkg.sv
`timescale 1ns / 1ps

package sbpf_pkg;

   // Item modes
   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_PARAM  = 2'd1;
   localparam logic [1:0] MODE_RX     = 2'd2;
   localparam logic [1:0] MODE_TICK   = 2'd3;

   // Result kinds
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_TIMEOUT    = 3'd1;
   localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
   localparam logic [2:0] STATUS_ID_BAD     = 3'd3;
   localparam logic [2:0] STATUS_BAD_LENGTH = 3'd4;
   localparam logic [2:0] STATUS_BAD_CSUM   = 3'd5;

   // Packet constants
   localparam logic [7:0] SYNC_BYTE      = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD   = 8'd2;
   localparam logic [7:0] RX_OVERHEAD    = 8'd4;
   localparam logic [7:0] UNBOUNDED_LEN  = 8'd255;
   localparam logic [7:0] CSUM_GOOD      = 8'hFF;

   // Register map
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic CSR_BROADCAST_ID = 1'b0;
   localparam logic CSR_TIMEOUT      = 1'b1;
   localparam logic [7:0]  BROADCAST_RESET = 8'd254;
   localparam logic [19:0] TIMEOUT_RESET   = 20'd1000;

   // Most results that one transaction can produce
   localparam int unsigned MAX_RESULTS = 7;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_PARAMS = 3'b010,
      PH_REPLY  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] target_id;
      logic [7:0] instruction;
      logic [7:0] param_count;
      logic [7:0] reply_length;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [2:0] status;
      logic [7:0] received_count;
   } result_type;

   typedef struct packed {
      logic [2:0]                         count;
      result_type [MAX_RESULTS-1:0]       entry;
   } bundle_type;

endpackage

// File: rtl/sbpf_if.sv
`timescale 1ns / 1ps

// Request channel: one command or receive-side transaction
interface sbpf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] target_id;
   logic [7:0] instruction;
   logic [7:0] param_count;
   logic [7:0] reply_length;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output target_id, output instruction,
                   output param_count, output reply_length, output data_byte,
                   input ready);
   modport sink   (input valid, input mode, input target_id, input instruction,
                   input param_count, input reply_length, input data_byte,
                   output ready);
endinterface

// Response channel: transmit bytes and reply verdicts
interface sbpf_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       tx_last;
   logic [2:0] status;
   logic [7:0] received_count;

   modport source (output valid, output kind, output tx_byte, output tx_last,
                   output status, output received_count, input ready);
   modport sink   (input valid, input kind, input tx_byte, input tx_last,
                   input status, input received_count, output ready);
endinterface

// File: rtl/sbpf_csr.sv
`timescale 1ns / 1ps

module sbpf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sbpf_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output logic [7:0]                          broadcast_id,
   output logic [19:0]                         timeout_ticks
);

   logic [7:0]  broadcast_id_ff;
   logic [19:0] timeout_ticks_ff;
   logic        reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;

   // Register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         broadcast_id_ff  <= sbpf_pkg::BROADCAST_RESET;
         timeout_ticks_ff <= sbpf_pkg::TIMEOUT_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            sbpf_pkg::CSR_BROADCAST_ID: broadcast_id_ff  <= pwdata[7:0];
            sbpf_pkg::CSR_TIMEOUT:      timeout_ticks_ff <= pwdata[19:0];
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         sbpf_pkg::CSR_BROADCAST_ID: prdata = {24'd0, broadcast_id_ff};
         sbpf_pkg::CSR_TIMEOUT:      prdata = {12'd0, timeout_ticks_ff};
      endcase
   end

   assign broadcast_id  = broadcast_id_ff;
   assign timeout_ticks = timeout_ticks_ff;

endmodule

// File: rtl/sbpf_core.sv
`timescale 1ns / 1ps

module sbpf_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  sbpf_pkg::item_type     item,
   input  logic [7:0]             broadcast_id,
   input  logic [19:0]            timeout_ticks,
   output sbpf_pkg::bundle_type   bundle
);

   sbpf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  current_target_ff, current_target_in;
   logic [7:0]  tx_sum_ff, tx_sum_in;
   logic [7:0]  params_left_ff, params_left_in;
   logic [7:0]  expected_reply_ff, expected_reply_in;
   logic [7:0]  reply_count_ff, reply_count_in;
   logic [7:0]  rx_sum_ff, rx_sum_in;
   logic [7:0]  length_field_ff, length_field_in;
   logic        header_bad_ff, header_bad_in;
   logic        id_bad_ff, id_bad_in;
   logic [20:0] wait_ticks_ff, wait_ticks_in;

   logic [7:0]  len_byte;
   logic [7:0]  hdr_sum;
   logic [7:0]  param_sum;
   logic [7:0]  left_next;
   sbpf_pkg::bundle_type bundle_in;

   function automatic sbpf_pkg::result_type tx_result(input logic [7:0] b, input logic last);
      sbpf_pkg::result_type r;
      r = '0;
      r.kind    = sbpf_pkg::KIND_TX;
      r.tx_byte = b;
      r.tx_last = last;
      return r;
   endfunction

   // Reply verdict (OK for the broadcast id) by priority: timeout, header, id, length, checksum
   function automatic sbpf_pkg::result_type verdict_result(
      input logic [7:0] target, input logic [7:0] bcast, input logic timed_out,
      input logic [7:0] expected, input logic [7:0] n, input logic hb,
      input logic ib, input logic [7:0] lf, input logic [7:0] rs);
      sbpf_pkg::result_type r;
      logic [2:0] st;
      st = sbpf_pkg::STATUS_OK;
      if (target != bcast) begin
         if (timed_out && expected != sbpf_pkg::UNBOUNDED_LEN) begin
            st = sbpf_pkg::STATUS_TIMEOUT;
         end else if (n > 8'd3) begin
            if (hb) begin
               st = sbpf_pkg::STATUS_BAD_HEADER;
            end else if (ib) begin
               st = sbpf_pkg::STATUS_ID_BAD;
            end else if (lf != n - sbpf_pkg::RX_OVERHEAD) begin
               st = sbpf_pkg::STATUS_BAD_LENGTH;
            end else if (rs != sbpf_pkg::CSUM_GOOD) begin
               st = sbpf_pkg::STATUS_BAD_CSUM;
            end
         end
      end
      r = '0;
      r.kind           = sbpf_pkg::KIND_VERDICT;
      r.status         = st;
      r.received_count = (st == sbpf_pkg::STATUS_OK) ? n : 8'd0;
      return r;
   endfunction

   assign len_byte  = item.param_count + sbpf_pkg::LEN_OVERHEAD;
   assign hdr_sum   = item.target_id + len_byte + item.instruction;
   assign param_sum = tx_sum_ff + item.data_byte;
   assign left_next = params_left_ff - 8'd1;

   // Next state and the results of this transaction
   always_comb begin
      phase_in          = phase_ff;
      current_target_in = current_target_ff;
      tx_sum_in         = tx_sum_ff;
      params_left_in    = params_left_ff;
      expected_reply_in = expected_reply_ff;
      reply_count_in    = reply_count_ff;
      rx_sum_in         = rx_sum_ff;
      length_field_in   = length_field_ff;
      header_bad_in     = header_bad_ff;
      id_bad_in         = id_bad_ff;
      wait_ticks_in     = wait_ticks_ff;
      bundle_in         = '0;

      unique case (item.mode)
         sbpf_pkg::MODE_HEADER: begin
            current_target_in  = item.target_id;
            expected_reply_in  = item.reply_length;
            params_left_in     = item.param_count;
            tx_sum_in          = hdr_sum;
            bundle_in.entry[0] = tx_result(sbpf_pkg::SYNC_BYTE, 1'b0);
            bundle_in.entry[1] = tx_result(sbpf_pkg::SYNC_BYTE, 1'b0);
            bundle_in.entry[2] = tx_result(item.target_id, 1'b0);
            bundle_in.entry[3] = tx_result(len_byte, 1'b0);
            bundle_in.entry[4] = tx_result(item.instruction, 1'b0);
            bundle_in.count    = 3'd5;
            if (item.param_count == 8'd0) begin
               bundle_in.entry[5] = tx_result(~hdr_sum, 1'b1);
               bundle_in.count    = 3'd6;
               phase_in           = sbpf_pkg::PH_REPLY;
               reply_count_in     = '0;
               rx_sum_in          = '0;
               length_field_in    = '0;
               header_bad_in      = 1'b0;
               id_bad_in          = 1'b0;
               wait_ticks_in      = '0;
               if (item.reply_length == 8'd0) begin
                  bundle_in.entry[6] = verdict_result(item.target_id, broadcast_id, 1'b0,
                                                      8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0);
                  bundle_in.count    = 3'd7;
                  phase_in           = sbpf_pkg::PH_IDLE;
               end
            end else begin
               phase_in = sbpf_pkg::PH_PARAMS;
            end
         end

         sbpf_pkg::MODE_PARAM: begin
            if (phase_ff == sbpf_pkg::PH_PARAMS) begin
               tx_sum_in          = param_sum;
               params_left_in     = left_next;
               bundle_in.entry[0] = tx_result(item.data_byte, 1'b0);
               bundle_in.count    = 3'd1;
               if (left_next == 8'd0) begin
                  bundle_in.entry[1] = tx_result(~param_sum, 1'b1);
                  bundle_in.count    = 3'd2;
                  phase_in           = sbpf_pkg::PH_REPLY;
                  reply_count_in     = '0;
                  rx_sum_in          = '0;
                  length_field_in    = '0;
                  header_bad_in      = 1'b0;
                  id_bad_in          = 1'b0;
                  wait_ticks_in      = '0;
                  if (expected_reply_ff == 8'd0) begin
                     bundle_in.entry[2] = verdict_result(current_target_ff, broadcast_id,
                                                         1'b0, 8'd0, 8'd0, 1'b0, 1'b0,
                                                         8'd0, 8'd0);
                     bundle_in.count    = 3'd3;
                     phase_in           = sbpf_pkg::PH_IDLE;
                  end
               end
            end
         end

         sbpf_pkg::MODE_RX: begin
            if (phase_ff == sbpf_pkg::PH_REPLY) begin
               if (reply_count_ff < 8'd2 && item.data_byte != sbpf_pkg::SYNC_BYTE) begin
                  header_bad_in = 1'b1;
               end
               if (reply_count_ff == 8'd2 && item.data_byte != current_target_ff) begin
                  id_bad_in = 1'b1;
               end
               if (reply_count_ff == 8'd3) begin
                  length_field_in = item.data_byte;
               end
               if (reply_count_ff >= 8'd2) begin
                  rx_sum_in = rx_sum_ff + item.data_byte;
               end
               reply_count_in = reply_count_ff + 8'd1;
               wait_ticks_in  = '0;
               if (reply_count_in == expected_reply_ff) begin
                  bundle_in.entry[0] = verdict_result(current_target_ff, broadcast_id, 1'b0,
                                                      expected_reply_ff, reply_count_in,
                                                      header_bad_in, id_bad_in,
                                                      length_field_in, rx_sum_in);
                  bundle_in.count    = 3'd1;
                  phase_in           = sbpf_pkg::PH_IDLE;
               end
            end
         end

         sbpf_pkg::MODE_TICK: begin
            if (phase_ff == sbpf_pkg::PH_REPLY) begin
               if (wait_ticks_ff > {1'b0, timeout_ticks}) begin
                  bundle_in.entry[0] = verdict_result(current_target_ff, broadcast_id, 1'b1,
                                                      expected_reply_ff, reply_count_ff,
                                                      header_bad_ff, id_bad_ff,
                                                      length_field_ff, rx_sum_ff);
                  bundle_in.count    = 3'd1;
                  phase_in           = sbpf_pkg::PH_IDLE;
               end else begin
                  wait_ticks_in = wait_ticks_ff + 21'd1;
               end
            end
         end
      endcase
   end

   // State registers advance only on a taken transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= sbpf_pkg::PH_IDLE;
         current_target_ff <= '0;
         tx_sum_ff         <= '0;
         params_left_ff    <= '0;
         expected_reply_ff <= '0;
         reply_count_ff    <= '0;
         rx_sum_ff         <= '0;
         length_field_ff   <= '0;
         header_bad_ff     <= 1'b0;
         id_bad_ff         <= 1'b0;
         wait_ticks_ff     <= '0;
      end else if (take) begin
         phase_ff          <= phase_in;
         current_target_ff <= current_target_in;
         tx_sum_ff         <= tx_sum_in;
         params_left_ff    <= params_left_in;
         expected_reply_ff <= expected_reply_in;
         reply_count_ff    <= reply_count_in;
         rx_sum_ff         <= rx_sum_in;
         length_field_ff   <= length_field_in;
         header_bad_ff     <= header_bad_in;
         id_bad_ff         <= id_bad_in;
         wait_ticks_ff     <= wait_ticks_in;
      end
   end

   assign bundle = bundle_in;

`ifndef NO_ASSERTIONS
   // Reply phase is only entered once every parameter has been sent
   a_reply_no_params_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sbpf_pkg::PH_REPLY) |-> (params_left_ff == 8'd0))
      else $error("reply phase with parameters outstanding");

   // A header always yields at least the five framing bytes
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (take && item.mode == sbpf_pkg::MODE_HEADER) |-> (bundle_in.count >= 3'd5))
      else $error("header produced too few bytes");

   // Tick or receive transactions never produce transmit bytes
   a_rx_no_tx: assert property (@(posedge clock) disable iff (reset)
      (take && (item.mode == sbpf_pkg::MODE_RX || item.mode == sbpf_pkg::MODE_TICK)
       && bundle_in.count != 3'd0) |-> (bundle_in.entry[0].kind == sbpf_pkg::KIND_VERDICT
       && phase_in == sbpf_pkg::PH_IDLE))
      else $error("receive side result is not a closing verdict");
`endif

endmodule

// File: rtl/sbpf_out_buf.sv
`timescale 1ns / 1ps

module sbpf_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  sbpf_pkg::bundle_type  bundle,
   output logic                  free,
   sbpf_rsp_if.source            rsp_ch
);

   sbpf_pkg::result_type [sbpf_pkg::MAX_RESULTS-1:0] entry_ff, entry_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic       load;

   assign pop  = (count_ff != 3'd0) && rsp_ch.ready;
   assign free = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ch.ready);
   assign load = take && (bundle.count != 3'd0);

   // Load a new result list, or shift the head out on each accepted response
   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = bundle.entry;
         count_in = bundle.count;
      end else if (pop) begin
         for (int i = 0; i < sbpf_pkg::MAX_RESULTS - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign rsp_ch.valid          = (count_ff != 3'd0);
   assign rsp_ch.kind           = entry_ff[0].kind;
   assign rsp_ch.tx_byte        = entry_ff[0].tx_byte;
   assign rsp_ch.tx_last        = entry_ff[0].tx_last;
   assign rsp_ch.status         = entry_ff[0].status;
   assign rsp_ch.received_count = entry_ff[0].received_count;

`ifndef NO_ASSERTIONS
   // A new list never overwrites results still waiting to leave
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == 3'd0 || (count_ff == 3'd1 && pop)))
      else $error("result list overwritten");

   // Pending count stays within the list size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(sbpf_pkg::MAX_RESULTS))
      else $error("result count out of range");
`endif

endmodule

// File: rtl/servo_bus_packet_framer_checker_top.sv
`timescale 1ns / 1ps

// Servo-bus packet framer and reply checker. Each request transaction is
// registered, then processed combinationally into a list of up to seven
// results that leave one per cycle on the response channel while it is
// ready: a command header gives 5 bytes (6 with the checksum when it
// has no parameters, 7 with a zero-length verdict), a parameter byte
// gives 0 to 3, a received byte or tick 0 or 1. A request waits in the
// input register until the result list is free, then its results load
// into the output buffer. A new request is taken every cycle while the
// result list is empty or leaving its last entry, so a header holds the
// request side until its results drain; the response drain sets the rate.
// Registers: broadcast_id at 0x0, timeout_ticks at 0x4; write them only
// while no transaction is in flight.
module servo_bus_packet_framer_checker_top (
   input  logic                                clock,
   input  logic                                reset,
   sbpf_req_if.sink                            req_ch,
   sbpf_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sbpf_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic                 in_valid_ff, in_valid_in;
   sbpf_pkg::item_type   in_item_ff;
   logic                 take;
   logic                 free;
   logic                 accept;
   logic [7:0]           broadcast_id;
   logic [19:0]          timeout_ticks;
   sbpf_pkg::bundle_type bundle;

   sbpf_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .broadcast_id  (broadcast_id),
      .timeout_ticks (timeout_ticks)
   );

   // Input register
   assign take         = in_valid_ff && free;
   assign req_ch.ready = !in_valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.mode         <= req_ch.mode;
         in_item_ff.target_id    <= req_ch.target_id;
         in_item_ff.instruction  <= req_ch.instruction;
         in_item_ff.param_count  <= req_ch.param_count;
         in_item_ff.reply_length <= req_ch.reply_length;
         in_item_ff.data_byte    <= req_ch.data_byte;
      end
   end

   sbpf_core u_core (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .item          (in_item_ff),
      .broadcast_id  (broadcast_id),
      .timeout_ticks (timeout_ticks),
      .bundle        (bundle)
   );

   sbpf_out_buf u_out_buf (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .bundle (bundle),
      .free   (free),
      .rsp_ch (rsp_ch)
   );

endmodule
